// ----- hw/rtl/mesh_vertex_normal_accumulator_unit_defines.svh -----
`ifndef MESH_VERTEX_NORMAL_ACCUMULATOR_UNIT_DEFINES_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MVNA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mvna assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MVNA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mvna assertion failed");

`endif

// ----- hw/rtl/mvna_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mvna_pkg;

  localparam int IdxW     = 10;
  localparam int CoordW   = 16;
  localparam int NrmW     = 16;
  localparam int EdgeW    = 17;
  localparam int ProdW    = 34;
  localparam int CrossW   = 35;
  localparam int MagW     = 24;
  localparam int SqW      = 50;
  localparam int RootW    = 25;
  localparam int QuoW     = 15;
  localparam int FracW    = 14;
  localparam int InDataW  = 88;
  localparam int OutDataW = 48;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI  = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [NrmW-1:0]   nrm_t;
  typedef logic signed [EdgeW-1:0]  edge_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [CrossW-1:0] cross_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } pvec_t;

  typedef struct packed {
    nrm_t z;
    nrm_t y;
    nrm_t x;
  } nvec_t;

  function automatic cross_t nrm_ext(nrm_t v);
    return {{(CrossW-NrmW){v[NrmW-1]}}, v};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mvna_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mvna_ram #(
  parameter int Width = 48,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/mvna_norm.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mvna_norm (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire mvna_pkg::cross_t vec_i [3],
  output logic                 done_o,
  output mvna_pkg::nvec_t      res_o
);

  import mvna_pkg::*;

  typedef enum logic [4:0] {
    N_IDLE  = 5'b00001,
    N_SHIFT = 5'b00010,
    N_SQ    = 5'b00100,
    N_ROOT  = 5'b01000,
    N_DIV   = 5'b10000
  } nstate_e;

  nstate_e state_q;
  logic    done_q;
  logic [4:0] cnt_q;

  logic [CrossW-1:0] mag_q [3];
  logic [2:0]        neg_q;
  logic [2*MagW-1:0] prod_q;
  logic [SqW-1:0]    m2_q;
  logic [RootW:0]    rem_q;
  logic [RootW-1:0]  root_q;
  logic [RootW-1:0]  drem_q [3];
  logic [QuoW-1:0]   dlow_q [3];
  logic [QuoW-1:0]   quo_q  [3];
  nvec_t             res_q;

  logic [MagW-1:0]   sq_in;
  logic              too_big;
  logic [RootW+2:0]  rem_n;
  logic [RootW+2:0]  trial;
  logic              root_ge;
  logic [RootW:0]    rem_d;
  logic [RootW-1:0]  root_d;
  logic [RootW:0]    dt    [3];
  logic              dge   [3];
  logic [RootW-1:0]  drem_d[3];
  logic [MagW+FracW:0] numer [3];
  logic [NrmW-1:0]   qx    [3];

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    sq_in = mag_q[0][MagW-1:0];
      2'd1:    sq_in = mag_q[1][MagW-1:0];
      2'd2:    sq_in = mag_q[2][MagW-1:0];
      default: sq_in = '0;
    endcase
    too_big = (|mag_q[0][CrossW-1:MagW]) | (|mag_q[1][CrossW-1:MagW]) |
              (|mag_q[2][CrossW-1:MagW]);
    rem_n   = {rem_q, m2_q[SqW-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    root_ge = (rem_n >= trial);
    rem_d   = root_ge ? (RootW+1)'(rem_n - trial) : rem_n[RootW:0];
    root_d  = {root_q[RootW-2:0], root_ge};
    for (int i = 0; i < 3; i++) begin
      dt[i]     = {drem_q[i], dlow_q[i][QuoW-1]};
      dge[i]    = (dt[i] >= {1'b0, root_q});
      drem_d[i] = dge[i] ? RootW'(dt[i] - {1'b0, root_q}) : dt[i][RootW-1:0];
      numer[i]  = {1'b0, mag_q[i][MagW-1:0], {FracW{1'b0}}} +
                  {{(MagW+FracW+1-RootW+1){1'b0}}, root_d[RootW-1:1]};
      qx[i]     = {1'b0, quo_q[i][QuoW-2:0], dge[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        N_IDLE: begin
          if (start_i) begin
            state_q <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (!too_big) begin
            state_q <= N_SQ;
            cnt_q   <= '0;
          end
        end
        N_SQ: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd3) begin
            state_q <= N_ROOT;
            cnt_q   <= '0;
          end
        end
        N_ROOT: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(RootW-1)) begin
            cnt_q <= '0;
            if (root_d == '0) begin
              state_q <= N_IDLE;
              done_q  <= 1'b1;
            end else begin
              state_q <= N_DIV;
            end
          end
        end
        N_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(QuoW-1)) begin
            state_q <= N_IDLE;
            done_q  <= 1'b1;
            cnt_q   <= '0;
          end
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            neg_q[i] <= vec_i[i][CrossW-1];
            mag_q[i] <= vec_i[i][CrossW-1] ? CrossW'(-vec_i[i]) : vec_i[i];
          end
        end
      end
      N_SHIFT: begin
        m2_q <= '0;
        if (too_big) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end
      end
      N_SQ: begin
        prod_q <= sq_in * sq_in;
        if (cnt_q != 5'd0) m2_q <= m2_q + {2'b00, prod_q};
        rem_q  <= '0;
        root_q <= '0;
      end
      N_ROOT: begin
        m2_q   <= m2_q << 2;
        rem_q  <= rem_d;
        root_q <= root_d;
        if (cnt_q == 5'(RootW-1)) begin
          if (root_d == '0) begin
            res_q <= '0;
          end
          for (int i = 0; i < 3; i++) begin
            drem_q[i] <= {1'b0, numer[i][MagW+FracW:QuoW]};
            dlow_q[i] <= numer[i][QuoW-1:0];
            quo_q[i]  <= '0;
          end
        end
      end
      N_DIV: begin
        for (int i = 0; i < 3; i++) begin
          drem_q[i] <= drem_d[i];
          dlow_q[i] <= dlow_q[i] << 1;
          quo_q[i]  <= {quo_q[i][QuoW-2:0], dge[i]};
        end
        if (cnt_q == 5'(QuoW-1)) begin
          res_q.x <= neg_q[0] ? -nrm_t'(qx[0]) : nrm_t'(qx[0]);
          res_q.y <= neg_q[1] ? -nrm_t'(qx[1]) : nrm_t'(qx[1]);
          res_q.z <= neg_q[2] ? -nrm_t'(qx[2]) : nrm_t'(qx[2]);
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/mesh_vertex_normal_accumulator_unit.sv -----
// Vertex normal accumulator. A load beat (tuser OP_LOAD) writes a vertex position and
// clears its normal in the same cycle. A triangle beat (OP_TRI) takes the face normal
// of its three corners and adds it into each corner's stored normal, renormalizing
// after each add; it uses one shared normalizer, four times per triangle, whose square
// root works one result bit per cycle and whose three dividers work one quotient bit
// per cycle. A read beat (OP_READ) returns the stored normal through the
// normal memory's read register and then the output register, waiting while the
// output is stalled. After reset the normal memory is swept to zero, one entry per
// cycle, over all min(MAX_VERTICES, 1024) entries, and no beat is taken until the
// sweep ends. Triangles that use a vertex never loaded give undefined normals.
`timescale 1ns / 1ps
`default_nettype none

module mesh_vertex_normal_accumulator_unit #(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
  input  wire logic [mvna_pkg::InDataW-1:0]   s_axis_tdata,
  // op
  input  wire logic [1:0]                     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic      [mvna_pkg::OutDataW-1:0]  m_axis_tdata
);

  import mvna_pkg::*;

  localparam int Depth = (MAX_VERTICES < (2 ** IdxW)) ? MAX_VERTICES : (2 ** IdxW);
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [11:0] {
    S_CLR   = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_RDN   = 12'b000000000100,
    S_PA    = 12'b000000001000,
    S_PB    = 12'b000000010000,
    S_PC    = 12'b000000100000,
    S_PCAP  = 12'b000001000000,
    S_XP    = 12'b000010000000,
    S_FN    = 12'b000100000000,
    S_NRD   = 12'b001000000000,
    S_NSUM  = 12'b010000000000,
    S_NWAIT = 12'b100000000000
  } state_e;

  state_e state_q;
  logic [AW-1:0] clr_q;
  logic [2:0]    xk_q;
  logic [1:0]    cidx_q;
  logic          out_valid_q;
  logic          zero_q;
  nvec_t         out_data_q;
  logic [AW-1:0] corner_q [3];
  pvec_t         pa_q;
  edge_t         e1_q [3];
  edge_t         e2_q [3];
  prod_t         prod_q;
  cross_t        cr_q [3];
  nvec_t         face_q;

  op_e           in_op;
  logic [IdxW-1:0] in_vi, in_ca, in_cb, in_cc;
  pvec_t         in_pos;
  logic          accept;
  logic          vi_ok, tri_ok;

  logic          pos_we, pos_re, nrm_we, nrm_re;
  logic [AW-1:0] pos_raddr, nrm_waddr, nrm_raddr;
  nvec_t         nrm_wdata;
  pvec_t         pos_rdata;
  nvec_t         nrm_rdata;

  logic          norm_start, norm_done;
  cross_t        norm_vec [3];
  nvec_t         norm_res;
  edge_t         mul_a, mul_b;

  assign in_op    = op_e'(s_axis_tuser);
  assign in_vi    = s_axis_tdata[9:0];
  assign in_pos.x = s_axis_tdata[25:10];
  assign in_pos.y = s_axis_tdata[41:26];
  assign in_pos.z = s_axis_tdata[57:42];
  assign in_ca    = s_axis_tdata[67:58];
  assign in_cb    = s_axis_tdata[77:68];
  assign in_cc    = s_axis_tdata[87:78];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign vi_ok         = (32'(in_vi) < MAX_VERTICES);
  assign tri_ok        = (32'(in_ca) < MAX_VERTICES) && (32'(in_cb) < MAX_VERTICES) &&
                         (32'(in_cc) < MAX_VERTICES);

  always_comb begin
    pos_we    = accept && (in_op == OP_LOAD) && vi_ok;
    pos_re    = (state_q == S_PA) || (state_q == S_PB) || (state_q == S_PC);
    case (state_q)
      S_PA:    pos_raddr = corner_q[0];
      S_PB:    pos_raddr = corner_q[1];
      default: pos_raddr = corner_q[2];
    endcase
    nrm_we    = 1'b0;
    nrm_waddr = corner_q[cidx_q];
    nrm_wdata = norm_res;
    if (state_q == S_CLR) begin
      nrm_we    = 1'b1;
      nrm_waddr = clr_q;
      nrm_wdata = '0;
    end else if (pos_we) begin
      nrm_we    = 1'b1;
      nrm_waddr = in_vi[AW-1:0];
      nrm_wdata = '0;
    end else if (state_q == S_NWAIT && norm_done) begin
      nrm_we    = 1'b1;
    end
    nrm_re    = (accept && (in_op == OP_READ) && vi_ok) || (state_q == S_NRD);
    nrm_raddr = (state_q == S_NRD) ? corner_q[cidx_q] : in_vi[AW-1:0];
  end

  always_comb begin
    case (xk_q)
      3'd0:    begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
      3'd1:    begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
      3'd2:    begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
      3'd3:    begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
      3'd4:    begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
      3'd5:    begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
      default: begin mul_a = '0;      mul_b = '0;      end
    endcase
  end

  always_comb begin
    norm_start = (state_q == S_XP && xk_q == 3'd7) || (state_q == S_NSUM);
    if (state_q == S_NSUM) begin
      norm_vec[0] = nrm_ext(nrm_rdata.x) + nrm_ext(face_q.x);
      norm_vec[1] = nrm_ext(nrm_rdata.y) + nrm_ext(face_q.y);
      norm_vec[2] = nrm_ext(nrm_rdata.z) + nrm_ext(face_q.z);
    end else begin
      norm_vec[0] = cr_q[0];
      norm_vec[1] = cr_q[1];
      norm_vec[2] = cr_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      xk_q        <= '0;
      cidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_RDN && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(Depth - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            case (in_op)
              OP_READ: state_q <= S_RDN;
              OP_TRI:  if (tri_ok) state_q <= S_PA;
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_RDN: begin
          if (!out_valid_q || m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        S_PA:   state_q <= S_PB;
        S_PB:   state_q <= S_PC;
        S_PC:   state_q <= S_PCAP;
        S_PCAP: begin
          state_q <= S_XP;
          xk_q    <= '0;
        end
        S_XP: begin
          xk_q <= xk_q + 3'd1;
          if (xk_q == 3'd7) state_q <= S_FN;
        end
        S_FN: begin
          if (norm_done) begin
            cidx_q  <= '0;
            state_q <= S_NRD;
          end
        end
        S_NRD:  state_q <= S_NSUM;
        S_NSUM: state_q <= S_NWAIT;
        S_NWAIT: begin
          if (norm_done) begin
            if (cidx_q == 2'd2) begin
              state_q <= S_IDLE;
            end else begin
              cidx_q  <= cidx_q + 2'd1;
              state_q <= S_NRD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      zero_q      <= !vi_ok;
      corner_q[0] <= in_ca[AW-1:0];
      corner_q[1] <= in_cb[AW-1:0];
      corner_q[2] <= in_cc[AW-1:0];
    end
    if (state_q == S_RDN && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= zero_q ? '0 : nrm_rdata;
    end
    if (state_q == S_PB) pa_q <= pos_rdata;
    if (state_q == S_PC) begin
      e1_q[0] <= {pos_rdata.x[CoordW-1], pos_rdata.x} - {pa_q.x[CoordW-1], pa_q.x};
      e1_q[1] <= {pos_rdata.y[CoordW-1], pos_rdata.y} - {pa_q.y[CoordW-1], pa_q.y};
      e1_q[2] <= {pos_rdata.z[CoordW-1], pos_rdata.z} - {pa_q.z[CoordW-1], pa_q.z};
    end
    if (state_q == S_PCAP) begin
      e2_q[0] <= {pos_rdata.x[CoordW-1], pos_rdata.x} - {pa_q.x[CoordW-1], pa_q.x};
      e2_q[1] <= {pos_rdata.y[CoordW-1], pos_rdata.y} - {pa_q.y[CoordW-1], pa_q.y};
      e2_q[2] <= {pos_rdata.z[CoordW-1], pos_rdata.z} - {pa_q.z[CoordW-1], pa_q.z};
    end
    if (state_q == S_XP) begin
      prod_q <= mul_a * mul_b;
      case (xk_q)
        3'd1:    cr_q[0] <= cross_t'(prod_q);
        3'd2:    cr_q[0] <= cr_q[0] - cross_t'(prod_q);
        3'd3:    cr_q[1] <= cross_t'(prod_q);
        3'd4:    cr_q[1] <= cr_q[1] - cross_t'(prod_q);
        3'd5:    cr_q[2] <= cross_t'(prod_q);
        3'd6:    cr_q[2] <= cr_q[2] - cross_t'(prod_q);
        default: ;
      endcase
    end
    if (state_q == S_FN && norm_done) face_q <= norm_res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  mvna_ram #(
    .Width ($bits(pvec_t)),
    .Depth (Depth)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (in_vi[AW-1:0]),
    .wdata_i (in_pos),
    .re_i    (pos_re),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  mvna_ram #(
    .Width ($bits(nvec_t)),
    .Depth (Depth)
  ) u_nrm_ram (
    .clk_i   (clk_i),
    .we_i    (nrm_we),
    .waddr_i (nrm_waddr),
    .wdata_i (nrm_wdata),
    .re_i    (nrm_re),
    .raddr_i (nrm_raddr),
    .rdata_o (nrm_rdata)
  );

  mvna_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .vec_i   (norm_vec),
    .done_o  (norm_done),
    .res_o   (norm_res)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/mvna_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "mesh_vertex_normal_accumulator_unit_defines.svh"

module mvna_checker #(
  parameter int MAX_VERTICES = 1024
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [mvna_pkg::InDataW-1:0]  s_axis_tdata,
  input wire logic [1:0]                    s_axis_tuser,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [mvna_pkg::OutDataW-1:0] m_axis_tdata
);

  import mvna_pkg::*;

  logic        in_beat;
  logic        tri_beat;
  logic        rd_beat;
  logic        norm_ok;
  nrm_t        nx, ny, nz;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign rd_beat  = in_beat && (s_axis_tuser == OP_READ);
  assign tri_beat = in_beat && (s_axis_tuser == OP_TRI) &&
                    (32'(s_axis_tdata[67:58]) < MAX_VERTICES) &&
                    (32'(s_axis_tdata[77:68]) < MAX_VERTICES) &&
                    (32'(s_axis_tdata[87:78]) < MAX_VERTICES);
  assign nx = m_axis_tdata[15:0];
  assign ny = m_axis_tdata[31:16];
  assign nz = m_axis_tdata[47:32];
  assign norm_ok = (nx >= -16'sd16384) && (nx <= 16'sd16384) &&
                   (ny >= -16'sd16384) && (ny <= 16'sd16384) &&
                   (nz >= -16'sd16384) && (nz <= 16'sd16384);

  `MVNA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `MVNA_ASSERT_IMP(a_norm_range, m_axis_tvalid, norm_ok)
  `MVNA_ASSERT_NXT(a_tri_busy, tri_beat, !s_axis_tready)
  `MVNA_ASSERT_NXT(a_read_busy, rd_beat, !s_axis_tready)

endmodule

bind mesh_vertex_normal_accumulator_unit mvna_checker #(
  .MAX_VERTICES (MAX_VERTICES)
) u_mvna_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- verif/tb_mesh_vertex_normal_accumulator_unit.sv -----
`timescale 1ns / 1ps

module tb_mesh_vertex_normal_accumulator_unit;
  import mvna_pkg::*;

  localparam int NumVert   = 1024;
  localparam int CycleCap  = 2000000;
  localparam int PoolSize  = 24;

  typedef struct {
    op_e          op;
    logic [9:0]   vi;
    coord_t       px, py, pz;
    logic [9:0]   ca, cb, cc;
  } beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  mesh_vertex_normal_accumulator_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  pvec_t       pos_mem [NumVert];
  nvec_t       nrm_mem [NumVert];
  bit          loaded [NumVert];
  nvec_t       normals_due [$];
  logic [9:0]  pool [PoolSize];
  int          errs = 0;
  int          cycles = 0;
  bit          calm = 1'b0;
  int          rd_stall = 0;

  initial forever #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic nvec_t unit_of(longint v0, longint v1, longint v2);
    longint          s [3];
    longint unsigned m [3];
    longint unsigned top, m2, r, q;
    nrm_t            o [3];
    nvec_t           res;
    s[0] = v0; s[1] = v1; s[2] = v2;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = s[i] < 0 ? -s[i] : s[i];
      if (m[i] > top) top = m[i];
    end
    while (top >= (64'd1 << 24)) begin
      top >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    m2 = 0;
    for (int i = 0; i < 3; i++) m2 += m[i] * m[i];
    r = isqrt(m2);
    for (int i = 0; i < 3; i++) begin
      q = (r == 0) ? 0 : (m[i] * 16384 + r / 2) / r;
      o[i] = s[i] < 0 ? -nrm_t'(q) : nrm_t'(q);
    end
    res.x = o[0]; res.y = o[1]; res.z = o[2];
    return res;
  endfunction

  function automatic void add_face(logic [9:0] idx, nvec_t f);
    nvec_t n;
    n = nrm_mem[idx];
    nrm_mem[idx] = unit_of(longint'(n.x) + f.x, longint'(n.y) + f.y, longint'(n.z) + f.z);
  endfunction

  function automatic void predict_normals(beat_t b);
    longint e1 [3], e2 [3];
    pvec_t  pa, pb, pc;
    nvec_t  f;
    case (b.op)
      OP_LOAD: begin
        pos_mem[b.vi] = '{z: b.pz, y: b.py, x: b.px};
        nrm_mem[b.vi] = '0;
        loaded[b.vi] = 1'b1;
      end
      OP_TRI: begin
        pa = pos_mem[b.ca]; pb = pos_mem[b.cb]; pc = pos_mem[b.cc];
        e1[0] = longint'(pb.x) - pa.x; e1[1] = longint'(pb.y) - pa.y;
        e1[2] = longint'(pb.z) - pa.z;
        e2[0] = longint'(pc.x) - pa.x; e2[1] = longint'(pc.y) - pa.y;
        e2[2] = longint'(pc.z) - pa.z;
        f = unit_of(e1[1] * e2[2] - e1[2] * e2[1], e1[2] * e2[0] - e1[0] * e2[2],
                    e1[0] * e2[1] - e1[1] * e2[0]);
        add_face(b.ca, f);
        add_face(b.cb, f);
        add_face(b.cc, f);
      end
      OP_READ: normals_due.push_back(nrm_mem[b.vi]);
      default: ;
    endcase
  endfunction

  task automatic send_beat(beat_t b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= b.op;
    s_axis_tdata  <= {b.cc, b.cb, b.ca, b.pz, b.py, b.px, b.vi};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_normals(b);
  endtask

  function automatic beat_t noise_beat(op_e op);
    beat_t b;
    b.op = op;
    b.vi = 10'($urandom);
    b.px = coord_t'($urandom); b.py = coord_t'($urandom); b.pz = coord_t'($urandom);
    b.ca = 10'($urandom); b.cb = 10'($urandom); b.cc = 10'($urandom);
    return b;
  endfunction

  task automatic load_vertex(logic [9:0] idx, coord_t x, coord_t y, coord_t z);
    beat_t b;
    b = noise_beat(OP_LOAD);
    b.vi = idx; b.px = x; b.py = y; b.pz = z;
    send_beat(b);
  endtask

  task automatic triangle(logic [9:0] a, logic [9:0] bb, logic [9:0] c);
    beat_t b;
    b = noise_beat(OP_TRI);
    b.ca = a; b.cb = bb; b.cc = c;
    send_beat(b);
  endtask

  task automatic read_normal(logic [9:0] idx);
    beat_t b;
    b = noise_beat(OP_READ);
    b.vi = idx;
    send_beat(b);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (normals_due.size() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (calm || rd_stall == 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      rd_stall <= rd_stall - 1;
    end
  end

  always @(posedge clk_i) begin
    nvec_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      rd_stall <= $urandom_range(0, 9);
      if (normals_due.size() == 0) begin
        $display("%0t: unexpected normal %h", $time, m_axis_tdata);
        errs++;
      end else begin
        want = normals_due.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: normal_x expected %0d actual %0d", $time, want.x, got.x);
          errs++;
        end
        if (got.y !== want.y) begin
          $display("%0t: normal_y expected %0d actual %0d", $time, want.y, got.y);
          errs++;
        end
        if (got.z !== want.z) begin
          $display("%0t: normal_z expected %0d actual %0d", $time, want.z, got.z);
          errs++;
        end
      end
    end
  end

  task automatic test_extremes();
    load_vertex(10'd0, 16'sh7fff, 16'sh7fff, 16'sh8000);
    load_vertex(10'd1023, 16'sh8000, 16'sh7fff, 16'sh7fff);
    load_vertex(10'd682, 16'sh8000, 16'sh8000, 16'sh8000);
    triangle(10'd0, 10'd1023, 10'd682);
    read_normal(10'd0);
    read_normal(10'd1023);
    read_normal(10'd682);
    read_normal(10'd341);
    send_beat(noise_beat(OP_NOP));
  endtask

  task automatic test_special_cases();
    load_vertex(10'd5, 16'sd0, 16'sd0, 16'sd0);
    load_vertex(10'd6, 16'sd256, 16'sd0, 16'sd0);
    load_vertex(10'd7, 16'sd0, 16'sd256, 16'sd0);
    triangle(10'd5, 10'd6, 10'd7);
    triangle(10'd5, 10'd7, 10'd6);
    read_normal(10'd5);
    triangle(10'd5, 10'd5, 10'd5);
    triangle(10'd6, 10'd6, 10'd7);
    triangle(10'd5, 10'd6, 10'd7);
    read_normal(10'd6);
    read_normal(10'd7);
    load_vertex(10'd7, 16'sd3, 16'sd1, -16'sd9);
    read_normal(10'd7);
  endtask

  task automatic refill_pool(int k);
    pool[k] = 10'($urandom);
    if ($urandom_range(0, 1))
      load_vertex(pool[k], coord_t'($urandom_range(0, 1024) - 512),
                  coord_t'($urandom_range(0, 1024) - 512),
                  coord_t'($urandom_range(0, 1024) - 512));
    else
      load_vertex(pool[k], coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
  endtask

  task automatic test_random(int n);
    int     pick;
    logic [9:0] a, b, c;
    for (int k = 0; k < PoolSize; k++) refill_pool(k);
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 100) calm = ~calm;
      if (i == n / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        refill_pool($urandom_range(0, PoolSize - 1));
      end else if (pick < 20) begin
        load_vertex(10'($urandom), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom));
      end else if (pick < 55) begin
        a = pool[$urandom_range(0, PoolSize - 1)];
        b = pool[$urandom_range(0, PoolSize - 1)];
        c = pool[$urandom_range(0, PoolSize - 1)];
        triangle(a, b, c);
      end else if (pick < 85) begin
        read_normal(pool[$urandom_range(0, PoolSize - 1)]);
      end else if (pick < 97) begin
        read_normal(10'($urandom));
      end else begin
        send_beat(noise_beat(OP_NOP));
        i--;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NumVert; i++) begin
      pos_mem[i] = '0;
      nrm_mem[i] = '0;
      loaded[i] = 1'b0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_special_cases();
    test_random(1400);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (errs == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
